[rtl/psri_pkg.sv]
package psri_pkg;

  // sizes
  localparam int unsigned NUM_VOICES     = 8;
  localparam int unsigned REG_BYTES      = 560;
  localparam int unsigned RAM_BYTES      = 16384;
  localparam int unsigned ROM_BANK_BYTES = 131072;

  localparam int unsigned REG_AW    = 10;
  localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);
  localparam int unsigned PORT_W    = 17;
  localparam int unsigned ADDR_W    = 25;
  localparam int unsigned VOICE_W   = 3;
  localparam int unsigned POS_BYTES = 3;
  localparam int unsigned LATCH_N   = NUM_VOICES * POS_BYTES;
  localparam int unsigned LATCH_W   = $clog2(LATCH_N);

  // register map
  localparam logic [REG_AW-1:0] A_KEYON     = 10'h214;
  localparam logic [REG_AW-1:0] A_KEYOFF    = 10'h215;
  localparam logic [REG_AW-1:0] A_KEYSTAT   = 10'h22c;
  localparam logic [REG_AW-1:0] A_PORT      = 10'h22d;
  localparam logic [REG_AW-1:0] A_ZONE      = 10'h22e;
  localparam logic [REG_AW-1:0] A_CTRL      = 10'h22f;
  localparam logic [REG_AW-1:0] A_VOICE_END = 10'h100;
  localparam logic [4:0]        POS_FIRST   = 5'hc;
  localparam logic [7:0]        ZONE_RAM    = 8'h80;

  // control byte bits
  localparam int unsigned CTRL_LATCH_BIT  = 0;
  localparam int unsigned CTRL_PORT_RD    = 4;
  localparam int unsigned CTRL_FREEZE_BIT = 7;

  localparam logic [7:0] VOICE_MASK = 8'((1 << NUM_VOICES) - 1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_KEYON,
    S_PUSH
  } seq_state_e;

  typedef struct packed {
    op_e         op;
    logic [9:0]  offset;
    logic [7:0]  data;
    logic [7:0]  rom_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [24:0] port_address;
    logic        port_targets_ram;
  } out_beat_t;

  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] addr;
    logic [7:0]        wdata;
  } reg_req_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        wdata;
  } smp_req_t;

endpackage

[rtl/psri_reg_mem.sv]
module psri_reg_mem (
  input  logic                clk_i,
  input  psri_pkg::reg_req_t  req_i,
  output logic [7:0]          rdata_o
);

  logic [7:0] mem [psri_pkg::REG_BYTES];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.addr];
  end

endmodule

[rtl/psri_sample_mem.sv]
module psri_sample_mem (
  input  logic                clk_i,
  input  psri_pkg::smp_req_t  req_i,
  output logic [7:0]          rdata_o
);

  logic [7:0] mem [psri_pkg::RAM_BYTES];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.addr];
  end

endmodule

[rtl/psri_seq.sv]
module psri_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clr_done_i,
  input  logic                 update_at_keyon_i,
  input  logic                 in_valid_i,
  input  psri_pkg::in_beat_t   in_beat_i,
  output logic                 in_ready_o,
  input  logic                 out_free_i,
  output logic                 res_load_o,
  output psri_pkg::out_beat_t  res_o,
  output psri_pkg::reg_req_t   reg_req_o,
  input  logic [7:0]           reg_rdata_i,
  output psri_pkg::smp_req_t   smp_req_o,
  input  logic [7:0]           smp_rdata_i
);

  localparam int unsigned LW = psri_pkg::LATCH_W;
  localparam int unsigned PW = psri_pkg::PORT_W;

  psri_pkg::seq_state_e state_q, state_d;
  psri_pkg::in_beat_t   req_q, req_d;
  logic [7:0]           res_q, res_d;
  logic [7:0]           ctrl_q, ctrl_d;
  logic [7:0]           keystat_q, keystat_d;
  logic [PW-1:0]        port_off_q, port_off_d;
  logic                 zone_ram_q, zone_ram_d;
  logic [7:0]           zone_bank_q, zone_bank_d;
  logic [psri_pkg::VOICE_W-1:0] kv_q, kv_d;
  logic [1:0]           kb_q, kb_d;
  logic [7:0]           plat_q [psri_pkg::LATCH_N];

  logic                 plat_we;
  logic [LW-1:0]        plat_widx;
  logic [LW-1:0]        plat_ridx;
  logic                 latch_en;
  logic                 in_range;
  logic                 is_pos;
  logic [4:0]           pos;
  logic [psri_pkg::VOICE_W-1:0] ch;
  logic [PW-1:0]        port_inc;
  logic [PW-1:0]        port_next;
  logic [PW:0]          port_limit;
  logic                 port_in_ram;
  logic [7:0]           key_bits;

  assign latch_en  = update_at_keyon_i & ctrl_q[psri_pkg::CTRL_LATCH_BIT];
  assign in_range  = req_q.offset < psri_pkg::REG_AW'(psri_pkg::REG_BYTES);
  assign pos       = req_q.offset[4:0];
  assign ch        = req_q.offset[5 +: psri_pkg::VOICE_W];
  assign is_pos    = latch_en && (req_q.offset < psri_pkg::A_VOICE_END)
                     && ({1'b0, ch} < (psri_pkg::VOICE_W + 1)'(psri_pkg::NUM_VOICES))
                     && (pos >= psri_pkg::POS_FIRST)
                     && (pos < psri_pkg::POS_FIRST + 5'(psri_pkg::POS_BYTES));
  assign plat_widx = LW'({ch, 1'b0}) + LW'(ch) + LW'(pos - psri_pkg::POS_FIRST);
  assign plat_ridx = LW'({kv_q, 1'b0}) + LW'(kv_q) + LW'(kb_q);
  assign key_bits  = req_q.data & psri_pkg::VOICE_MASK;

  // data port offset step with wrap at the zone size
  assign port_inc    = port_off_q + PW'(1);
  assign port_limit  = zone_ram_q ? (PW + 1)'(psri_pkg::RAM_BYTES)
                                  : (PW + 1)'(psri_pkg::ROM_BANK_BYTES);
  assign port_next   = ({1'b0, port_inc} >= port_limit) ? '0 : port_inc;
  assign port_in_ram = {1'b0, port_off_q} < (PW + 1)'(psri_pkg::RAM_BYTES);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    ctrl_d      = ctrl_q;
    keystat_d   = keystat_q;
    port_off_d  = port_off_q;
    zone_ram_d  = zone_ram_q;
    zone_bank_d = zone_bank_q;
    kv_d        = kv_q;
    kb_d        = kb_q;
    plat_we     = 1'b0;
    in_ready_o  = 1'b0;
    res_load_o  = 1'b0;

    reg_req_o.we    = 1'b0;
    reg_req_o.addr  = req_q.offset;
    reg_req_o.wdata = req_q.data;
    smp_req_o.we    = 1'b0;
    smp_req_o.addr  = port_off_q[psri_pkg::RAM_AW-1:0];
    smp_req_o.wdata = req_q.data;

    case (state_q)
      psri_pkg::S_IDLE: begin
        in_ready_o     = clr_done_i;
        reg_req_o.addr = in_beat_i.offset;
        if (in_valid_i && clr_done_i) begin
          req_d   = in_beat_i;
          state_d = psri_pkg::S_EXEC;
        end
      end
      psri_pkg::S_EXEC: begin
        res_d   = '0;
        state_d = psri_pkg::S_PUSH;
        if (!in_range) begin
          res_d = '0;
        end else if (req_q.op == psri_pkg::OP_READ) begin
          if (req_q.offset == psri_pkg::A_PORT) begin
            if (ctrl_q[psri_pkg::CTRL_PORT_RD]) begin
              if (zone_ram_q) begin
                res_d = port_in_ram ? smp_rdata_i : 8'h00;
              end else begin
                res_d = req_q.rom_byte;
              end
              port_off_d = port_next;
            end
          end else if (req_q.offset == psri_pkg::A_CTRL) begin
            res_d = ctrl_q;
          end else if (req_q.offset == psri_pkg::A_KEYSTAT) begin
            res_d = keystat_q;
          end else begin
            res_d = reg_rdata_i;
          end
        end else if (is_pos) begin
          // start position goes to the latch only
          plat_we = 1'b1;
        end else begin
          reg_req_o.we = 1'b1;
          if (req_q.offset == psri_pkg::A_CTRL) begin
            ctrl_d = req_q.data;
          end
          if (req_q.offset == psri_pkg::A_KEYSTAT) begin
            keystat_d = req_q.data;
          end
          if (req_q.offset == psri_pkg::A_KEYON) begin
            if (!ctrl_q[psri_pkg::CTRL_FREEZE_BIT]) begin
              keystat_d = keystat_q | key_bits;
            end
            if (latch_en && (key_bits != 8'h00)) begin
              kv_d    = '0;
              kb_d    = '0;
              state_d = psri_pkg::S_KEYON;
            end
          end
          if (req_q.offset == psri_pkg::A_KEYOFF) begin
            if (!ctrl_q[psri_pkg::CTRL_FREEZE_BIT]) begin
              keystat_d = keystat_q & ~key_bits;
            end
          end
          if (req_q.offset == psri_pkg::A_PORT) begin
            smp_req_o.we = zone_ram_q && port_in_ram;
            port_off_d   = port_next;
          end
          if (req_q.offset == psri_pkg::A_ZONE) begin
            zone_ram_d  = (req_q.data == psri_pkg::ZONE_RAM);
            zone_bank_d = req_q.data;
            port_off_d  = '0;
          end
        end
      end
      psri_pkg::S_KEYON: begin
        // one latched byte per cycle, voices in order
        reg_req_o.we    = req_q.data[kv_q];
        reg_req_o.addr  = psri_pkg::REG_AW'({kv_q, 5'h00}) + psri_pkg::REG_AW'(psri_pkg::POS_FIRST)
                          + psri_pkg::REG_AW'(kb_q);
        reg_req_o.wdata = plat_q[plat_ridx];
        if (kb_q == 2'(psri_pkg::POS_BYTES - 1)) begin
          kb_d = '0;
          kv_d = kv_q + 1'b1;
          if (kv_q == psri_pkg::VOICE_W'(psri_pkg::NUM_VOICES - 1)) begin
            state_d = psri_pkg::S_PUSH;
          end
        end else begin
          kb_d = kb_q + 1'b1;
        end
      end
      psri_pkg::S_PUSH: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          state_d    = psri_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = psri_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.read_data        = res_q;
    res_o.port_targets_ram = zone_ram_q;
    if (zone_ram_q) begin
      res_o.port_address = psri_pkg::ADDR_W'(port_off_q);
    end else begin
      res_o.port_address = psri_pkg::ADDR_W'(psri_pkg::ADDR_W'(zone_bank_q)
                           * psri_pkg::ADDR_W'(psri_pkg::ROM_BANK_BYTES))
                           + psri_pkg::ADDR_W'(port_off_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psri_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      keystat_q   <= '0;
      port_off_q  <= '0;
      zone_ram_q  <= 1'b0;
      zone_bank_q <= '0;
      kv_q        <= '0;
      kb_q        <= '0;
      for (int i = 0; i < psri_pkg::LATCH_N; i++) begin
        plat_q[i] <= '0;
      end
    end else begin
      ctrl_q      <= ctrl_d;
      keystat_q   <= keystat_d;
      port_off_q  <= port_off_d;
      zone_ram_q  <= zone_ram_d;
      zone_bank_q <= zone_bank_d;
      kv_q        <= kv_d;
      kb_q        <= kb_d;
      if (plat_we) begin
        plat_q[plat_widx] <= req_q.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

endmodule

[rtl/pcm_sound_register_interface_unit.sv]
// channel  | signals                          | beat taken when
// ---------+----------------------------------+-----------------------------
// input    | in_valid_i, in_ready_o, in_data_i | in_valid_i && in_ready_o
// output   | out_valid_o, out_ready_i, out_data_o | out_valid_o && out_ready_i
// config   | cfg_we_i, cfg_data_i             | cfg_we_i
//
// one beat at a time: accept, execute, then the result moves to the output
// register once that register is free; a key-on with latching walks all
// voices, one latched byte per cycle, before its result moves
// after reset a clearing pass zeroes sample ram and the register file, one
// entry per cycle, during which no input beat is taken
// a result waiting in the output register does not block the next input beat
module pcm_sound_register_interface_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  psri_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output psri_pkg::out_beat_t  out_data_o
);

  localparam int unsigned CW = psri_pkg::RAM_AW + 1;

  // start-position latching enable, set at reset
  logic update_at_keyon_q;

  // clearing pass counter
  logic [CW-1:0] clr_q, clr_d;
  logic          clr_done;

  // output register
  logic                 out_valid_q, out_valid_d;
  psri_pkg::out_beat_t  out_q;

  logic                 out_free;
  logic                 res_load;
  psri_pkg::out_beat_t  res;
  psri_pkg::reg_req_t   seq_reg_req, reg_req;
  psri_pkg::smp_req_t   seq_smp_req, smp_req;
  logic [7:0]           reg_rdata;
  logic [7:0]           smp_rdata;

  assign clr_done = (clr_q == CW'(psri_pkg::RAM_BYTES));
  assign clr_d    = clr_done ? clr_q : clr_q + 1'b1;

  // output register is free when empty or being drained this cycle
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_d = res_load || (out_valid_q && !out_ready_i);

  // clearing pass owns both memories until it finishes
  always_comb begin
    if (!clr_done) begin
      reg_req.we    = clr_q < CW'(psri_pkg::REG_BYTES);
      reg_req.addr  = psri_pkg::REG_AW'(clr_q);
      reg_req.wdata = 8'h00;
      smp_req.we    = 1'b1;
      smp_req.addr  = clr_q[psri_pkg::RAM_AW-1:0];
      smp_req.wdata = 8'h00;
    end else begin
      reg_req = seq_reg_req;
      smp_req = seq_smp_req;
    end
  end

  psri_seq u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .clr_done_i        (clr_done),
    .update_at_keyon_i (update_at_keyon_q),
    .in_valid_i        (in_valid_i),
    .in_beat_i         (in_data_i),
    .in_ready_o        (in_ready_o),
    .out_free_i        (out_free),
    .res_load_o        (res_load),
    .res_o             (res),
    .reg_req_o         (seq_reg_req),
    .reg_rdata_i       (reg_rdata),
    .smp_req_o         (seq_smp_req),
    .smp_rdata_i       (smp_rdata)
  );

  psri_reg_mem u_reg_mem (
    .clk_i   (clk_i),
    .req_i   (reg_req),
    .rdata_o (reg_rdata)
  );

  psri_sample_mem u_sample_mem (
    .clk_i   (clk_i),
    .req_i   (smp_req),
    .rdata_o (smp_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      update_at_keyon_q <= 1'b1;
      clr_q             <= '0;
      out_valid_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        update_at_keyon_q <= cfg_data_i;
      end
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // no beat taken while the clearing pass runs
  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_done |-> !in_ready_o)
    else $error("input taken during clearing pass");

  // one beat in flight: busy right after an accept
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat taken while busy");

  // a result is only loaded into a free output register
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> out_free)
    else $error("output register overwritten");

  // data port stays inside sample ram in the ram zone
  a_ram_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.port_targets_ram)
      |-> (out_data_o.port_address < psri_pkg::ADDR_W'(psri_pkg::RAM_BYTES)))
    else $error("data port offset beyond sample ram");

endmodule

[tb/sv/pcm_sound_register_interface_unit_tb.sv]
`timescale 1ns / 1ps

module pcm_sound_register_interface_unit_tb;
  import psri_pkg::*;

  localparam int unsigned HALF_PERIOD = 6;
  // longest quiet stretch is the clearing pass after reset
  localparam int unsigned QUIET_LIMIT = 50000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned DIR_ROWS    = 27;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_PERIODIC,
    RDY_LONG
  } rdy_mode_e;

  typedef enum logic [1:0] {
    SEQ_SINGLE,
    SEQ_KEYON,
    SEQ_PORT
  } seq_kind_e;

  // one row of the directed table; want is used only when typed is set
  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_data_i  = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b1;
  out_beat_t out_data_o;

  // shadow copy of the chip's state
  logic [7:0]        sh_regs  [REG_BYTES];
  logic [7:0]        sh_latch [LATCH_N];
  logic [7:0]        sh_ram   [RAM_BYTES];
  logic [PORT_W-1:0] sh_port_ofs;
  logic              sh_zone_ram;
  logic [7:0]        sh_bank;
  logic              sh_keyon_latch;

  out_beat_t   bus_replies [$];
  dir_row_t    dir_rows [DIR_ROWS];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent         = 0;
  int unsigned burst_left   = 0;
  bit          idle_en      = 1'b1;
  bit          stall_en     = 1'b1;
  rdy_mode_e   rdy_mode     = RDY_ALWAYS;
  logic [7:0]  rdy_tick     = '0;

  pcm_sound_register_interface_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // data port step, wrapping at the size of the current zone
  function automatic void port_step();
    int unsigned span;
    span = sh_zone_ram ? RAM_BYTES : ROM_BANK_BYTES;
    sh_port_ofs = sh_port_ofs + 1'b1;
    if (sh_port_ofs >= span) sh_port_ofs = '0;
  endfunction

  // applies one bus access to the shadow state and returns the chip's answer
  function automatic out_beat_t bus_access(in_beat_t b);
    out_beat_t   r;
    logic        latch_on;
    logic        frozen;
    logic        keep;
    int unsigned off;
    int unsigned slot;
    r        = '0;
    off      = b.offset;
    latch_on = sh_keyon_latch && sh_regs[A_CTRL][CTRL_LATCH_BIT];
    frozen   = sh_regs[A_CTRL][CTRL_FREEZE_BIT];
    // out of range: write dropped, read answers zero
    if (off < REG_BYTES) begin
      if (b.op == OP_READ) begin
        if (off == A_PORT) begin
          // port reads disabled: zero and no step
          if (sh_regs[A_CTRL][CTRL_PORT_RD]) begin
            if (sh_zone_ram)
              r.read_data = (sh_port_ofs < RAM_BYTES) ? sh_ram[sh_port_ofs[RAM_AW-1:0]] : 8'h00;
            else
              r.read_data = b.rom_byte;
            port_step();
          end
        end else begin
          r.read_data = sh_regs[off];
        end
      end else begin
        keep = 1'b1;
        if (latch_on && off < A_VOICE_END) begin
          slot = off & 'h1f;
          // start position bytes go to the latch only
          if ((off >> 5) < NUM_VOICES && slot >= POS_FIRST && slot < POS_FIRST + POS_BYTES) begin
            sh_latch[(off >> 5) * POS_BYTES + slot - POS_FIRST] = b.data;
            keep = 1'b0;
          end
        end else if (off == A_KEYON) begin
          for (int v = 0; v < NUM_VOICES; v++) begin
            if (b.data[v]) begin
              // latched bytes are copied even while frozen
              if (latch_on)
                for (int k = 0; k < POS_BYTES; k++)
                  sh_regs[v * 32 + POS_FIRST + k] = sh_latch[v * POS_BYTES + k];
              if (!frozen) sh_regs[A_KEYSTAT][v] = 1'b1;
            end
          end
        end else if (off == A_KEYOFF) begin
          for (int v = 0; v < NUM_VOICES; v++)
            if (b.data[v] && !frozen) sh_regs[A_KEYSTAT][v] = 1'b0;
        end else if (off == A_PORT) begin
          // rom zone: nothing stored, offset still steps
          if (sh_zone_ram && sh_port_ofs < RAM_BYTES) sh_ram[sh_port_ofs[RAM_AW-1:0]] = b.data;
          port_step();
        end else if (off == A_ZONE) begin
          sh_zone_ram = (b.data == ZONE_RAM);
          sh_bank     = b.data;
          sh_port_ofs = '0;
        end
        if (keep) sh_regs[off] = b.data;
      end
    end
    r.port_targets_ram = sh_zone_ram;
    r.port_address     = {sh_zone_ram ? 8'h00 : sh_bank, sh_port_ofs};
    return r;
  endfunction

  function automatic dir_row_t dir_row(op_e op, logic [9:0] off, logic [7:0] d,
                                       logic [7:0] rom, bit typed, logic [7:0] rd,
                                       logic [24:0] addr, logic ram);
    dir_row_t row;
    row.beat.op                = op;
    row.beat.offset            = off;
    row.beat.data              = d;
    row.beat.rom_byte          = rom;
    row.typed                  = typed;
    row.want.read_data         = rd;
    row.want.port_address      = addr;
    row.want.port_targets_ram  = ram;
    return row;
  endfunction

  // offsets weighted toward the interesting registers
  function automatic int unsigned pick_offset();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      case ($urandom_range(0, 5))
        0:       return A_KEYON;
        1:       return A_KEYOFF;
        2:       return A_KEYSTAT;
        3:       return A_PORT;
        4:       return A_ZONE;
        default: return A_CTRL;
      endcase
    end else if (pick < 45) begin
      return $urandom_range(REG_BYTES, 1023);
    end else if (pick < 70) begin
      return $urandom_range(0, NUM_VOICES - 1) * 32 + POS_FIRST + $urandom_range(0, POS_BYTES - 1);
    end
    return $urandom_range(0, REG_BYTES - 1);
  endfunction

  // drives one beat from a falling edge, holds it until taken, ends on a falling edge
  task automatic push_beat(input in_beat_t b, input bit typed, input out_beat_t want);
    out_beat_t ans;
    if (idle_en && burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    in_valid_i = 1'b1;
    in_data_i  = b;
    do @(posedge clk_i); while (!in_ready_o);
    ans = bus_access(b);
    bus_replies.push_back(typed ? want : ans);
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
  endtask

  task automatic send(input op_e op, input int unsigned off, input logic [7:0] d);
    in_beat_t b;
    b.op       = op;
    b.offset   = off[9:0];
    b.data     = d;
    b.rom_byte = 8'($urandom);
    push_beat(b, 1'b0, '0);
    sent++;
  endtask

  // sender pauses until every pending result is back
  task automatic settle();
    in_valid_i = 1'b0;
    while (bus_replies.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_keyon_latch(input logic val);
    cfg_we_i   = 1'b1;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    sh_keyon_latch = val;
  endtask

  // mostly well-formed latch/key-on and data port sequences, some loose accesses
  task automatic run_mix(input int unsigned n);
    int unsigned start;
    int unsigned reps;
    int unsigned v;
    logic [7:0]  d;
    logic [7:0]  zone;
    start = sent;
    while (sent - start < n) begin
      case (seq_kind_e'($urandom_range(0, 2)))
        SEQ_SINGLE: send(op_e'($urandom_range(0, 1)), pick_offset(), 8'($urandom));
        SEQ_KEYON: begin
          d = 8'($urandom);
          d[CTRL_LATCH_BIT]  = 1'b1;
          d[CTRL_FREEZE_BIT] = ($urandom_range(0, 3) == 0);
          send(OP_WRITE, A_CTRL, d);
          reps = $urandom_range(1, 6);
          v    = 0;
          repeat (reps) begin
            v = $urandom_range(0, NUM_VOICES - 1);
            send(OP_WRITE, v * 32 + POS_FIRST + $urandom_range(0, POS_BYTES - 1), 8'($urandom));
          end
          send(OP_WRITE, A_KEYON, 8'($urandom));
          send(OP_READ, v * 32 + POS_FIRST + $urandom_range(0, POS_BYTES - 1), 8'h00);
          send(OP_READ, A_KEYSTAT, 8'($urandom));
          if ($urandom_range(0, 1)) send(OP_WRITE, A_KEYOFF, 8'($urandom));
        end
        default: begin
          zone = $urandom_range(0, 1) ? ZONE_RAM : 8'($urandom);
          d = 8'($urandom);
          d[CTRL_PORT_RD] = ($urandom_range(0, 4) != 0);
          send(OP_WRITE, A_CTRL, d);
          send(OP_WRITE, A_ZONE, zone);
          reps = $urandom_range(1, 8);
          repeat (reps) send(OP_WRITE, A_PORT, 8'($urandom));
          // rewind and read back; in the ram zone with port reads on this returns what was just written
          send(OP_WRITE, A_ZONE, zone);
          repeat (reps + $urandom_range(0, 2)) send(OP_READ, A_PORT, 8'($urandom));
        end
      endcase
    end
  endtask

  // receiver: ready pattern picks a new random mode each time rdy_tick[5:0] returns to zero
  always @(negedge clk_i) begin
    rdy_tick++;
    if (rdy_tick[5:0] == 6'd0) rdy_mode = rdy_mode_e'($urandom_range(0, 3));
    if (!stall_en) begin
      out_ready_i = 1'b1;
    end else begin
      case (rdy_mode)
        RDY_ALWAYS:   out_ready_i = 1'b1;
        RDY_COIN:     out_ready_i = 1'($urandom_range(0, 1));
        RDY_PERIODIC: out_ready_i = (rdy_tick[2:0] >= 3'd3);
        default:      out_ready_i = (rdy_tick[4:0] < 5'd20);
      endcase
    end
  end

  // result checker and quiet-cycle count for the watchdog
  always @(posedge clk_i) begin : check_results
    out_beat_t want;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bus_replies.size() == 0) begin
        $error("result beat with no access pending");
        mismatches++;
      end else begin
        want = bus_replies.pop_front();
        if (out_data_o.read_data !== want.read_data) begin
          $error("read_data: expected %0h, got %0h", want.read_data, out_data_o.read_data);
          mismatches++;
        end
        if (out_data_o.port_address !== want.port_address) begin
          $error("port_address: expected %0h, got %0h",
                 want.port_address, out_data_o.port_address);
          mismatches++;
        end
        if (out_data_o.port_targets_ram !== want.port_targets_ram) begin
          $error("port_targets_ram: expected %0b, got %0b",
                 want.port_targets_ram, out_data_o.port_targets_ram);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("pcm_sound_register_interface_unit_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    foreach (sh_regs[i]) sh_regs[i] = '0;
    foreach (sh_latch[i]) sh_latch[i] = '0;
    foreach (sh_ram[i]) sh_ram[i] = '0;
    sh_port_ofs    = '0;
    sh_zone_ram    = 1'b0;
    sh_bank        = '0;
    sh_keyon_latch = 1'b1;

    // reset state, out-of-range accesses, disabled port read
    dir_rows[0]  = dir_row(OP_READ,  10'h000, 8'h00, 8'h00, 1, 8'h00, 25'h0, 1'b0);
    dir_rows[1]  = dir_row(OP_READ,  10'h3ff, 8'h00, 8'hff, 1, 8'h00, 25'h0, 1'b0);
    dir_rows[2]  = dir_row(OP_WRITE, 10'h3ff, 8'hff, 8'h00, 1, 8'h00, 25'h0, 1'b0);
    dir_rows[3]  = dir_row(OP_READ,  A_PORT,  8'h00, 8'ha5, 1, 8'h00, 25'h0, 1'b0);
    dir_rows[4]  = dir_row(OP_WRITE, 10'h000, 8'hff, 8'h00, 1, 8'h00, 25'h0, 1'b0);
    dir_rows[5]  = dir_row(OP_READ,  10'h000, 8'h00, 8'h00, 1, 8'hff, 25'h0, 1'b0);
    // latching on, start positions to the latch, key-on copies them
    dir_rows[6]  = dir_row(OP_WRITE, A_CTRL,  8'h11, 8'h00, 0, 8'h00, 25'h0, 1'b0);
    dir_rows[7]  = dir_row(OP_WRITE, 10'h00c, 8'haa, 8'h00, 0, 8'h00, 25'h0, 1'b0);
    dir_rows[8]  = dir_row(OP_WRITE, 10'h0ee, 8'h55, 8'h00, 0, 8'h00, 25'h0, 1'b0);
    dir_rows[9]  = dir_row(OP_WRITE, A_KEYON, 8'hff, 8'h00, 0, 8'h00, 25'h0, 1'b0);
    dir_rows[10] = dir_row(OP_READ,  10'h00c, 8'h00, 8'h00, 0, 8'h00, 25'h0, 1'b0);
    dir_rows[11] = dir_row(OP_READ,  A_KEYSTAT, 8'h00, 8'h00, 0, 8'h00, 25'h0, 1'b0);
    // frozen: key bits held, latched copy still happens
    dir_rows[12] = dir_row(OP_WRITE, A_CTRL,  8'h91, 8'h00, 0, 8'h00, 25'h0, 1'b0);
    dir_rows[13] = dir_row(OP_WRITE, A_KEYOFF, 8'hff, 8'h00, 0, 8'h00, 25'h0, 1'b0);
    dir_rows[14] = dir_row(OP_WRITE, 10'h02d, 8'h33, 8'h00, 0, 8'h00, 25'h0, 1'b0);
    dir_rows[15] = dir_row(OP_WRITE, A_KEYON, 8'h02, 8'h00, 0, 8'h00, 25'h0, 1'b0);
    dir_rows[16] = dir_row(OP_READ,  10'h02d, 8'h00, 8'h00, 0, 8'h00, 25'h0, 1'b0);
    // data port in ram, then in the top rom bank
    dir_rows[17] = dir_row(OP_WRITE, A_CTRL,  8'h10, 8'h00, 0, 8'h00, 25'h0, 1'b0);
    dir_rows[18] = dir_row(OP_WRITE, A_ZONE,  ZONE_RAM, 8'h00, 1, 8'h00, 25'h0, 1'b1);
    dir_rows[19] = dir_row(OP_WRITE, A_PORT,  8'h5a, 8'h00, 1, 8'h00, 25'h1, 1'b1);
    dir_rows[20] = dir_row(OP_WRITE, A_ZONE,  ZONE_RAM, 8'h00, 1, 8'h00, 25'h0, 1'b1);
    dir_rows[21] = dir_row(OP_READ,  A_PORT,  8'h00, 8'h00, 1, 8'h5a, 25'h1, 1'b1);
    dir_rows[22] = dir_row(OP_WRITE, A_ZONE,  8'hff, 8'h00, 1, 8'h00, 25'h1fe0000, 1'b0);
    dir_rows[23] = dir_row(OP_READ,  A_PORT,  8'h00, 8'hff, 1, 8'hff, 25'h1fe0001, 1'b0);
    dir_rows[24] = dir_row(OP_WRITE, A_PORT,  8'h00, 8'h00, 0, 8'h00, 25'h0, 1'b0);
    dir_rows[25] = dir_row(OP_WRITE, A_CTRL,  8'h00, 8'h00, 0, 8'h00, 25'h0, 1'b0);
    dir_rows[26] = dir_row(OP_READ,  A_PORT,  8'h00, 8'h3c, 1, 8'h00, 25'h1fe0002, 1'b0);

    // hold reset, then release it on a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    load_keyon_latch(1'b1);
    foreach (dir_rows[i]) push_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    settle();

    // latching off
    load_keyon_latch(1'b0);
    run_mix(280);
    settle();

    // latching back on
    load_keyon_latch(1'b1);
    run_mix(280);
    settle();

    // full rate with no idling and no output stalls
    idle_en  = 1'b0;
    stall_en = 1'b0;
    run_mix(120);
    settle();

    idle_en  = 1'b1;
    stall_en = 1'b1;
    load_keyon_latch(1'b0);
    run_mix(140);
    settle();

    // catch any stray result after the last one
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("pcm_sound_register_interface_unit_tb: PASS");
    else
      $display("pcm_sound_register_interface_unit_tb: FAIL");
    $finish;
  end

endmodule
